>>> rtl/sdif_pkg.sv
package sdif_pkg;

   localparam int unsigned WORD_W       = 32;
   localparam int unsigned HALF_W       = 16;
   localparam int unsigned KEPT_W       = 21;
   localparam int unsigned HDR_W        = 3;
   localparam int unsigned MAX_WORDS    = 1048576;
   localparam int unsigned HEADER_WORDS = 5;

   // kept count saturates at MAX_WORDS, or at the full counter range if that is smaller
   localparam longint unsigned KEPT_MASK = (64'd1 << KEPT_W) - 64'd1;
   localparam logic [KEPT_W-1:0] KEPT_CAP =
      (longint'(MAX_WORDS) > KEPT_MASK) ? KEPT_W'(KEPT_MASK) : KEPT_W'(MAX_WORDS);

   localparam logic [HDR_W-1:0] HDR_RESET = HDR_W'(HEADER_WORDS);

   // debug opcodes to strip
   localparam logic [HALF_W-1:0] OP_SOURCE_CONTINUED = 16'd2;
   localparam logic [HALF_W-1:0] OP_SOURCE           = 16'd3;
   localparam logic [HALF_W-1:0] OP_SOURCE_EXTENSION = 16'd4;
   localparam logic [HALF_W-1:0] OP_LINE             = 16'd8;
   localparam logic [HALF_W-1:0] OP_NO_LINE          = 16'd317;

   function automatic logic is_debug_op(input logic [HALF_W-1:0] op);
      return (op == OP_SOURCE_CONTINUED) || (op == OP_SOURCE) ||
             (op == OP_SOURCE_EXTENSION) || (op == OP_LINE) || (op == OP_NO_LINE);
   endfunction

endpackage

>>> rtl/sdif_channels.sv
interface sdif_req_if import sdif_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] word;
   logic              end_of_module;

   modport source (output valid, word, end_of_module, input ready);
   modport sink   (input valid, word, end_of_module, output ready);
endinterface

interface sdif_rsp_if import sdif_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] out_word;
   logic              word_valid;
   logic              is_last;
   logic              status;
   logic [KEPT_W-1:0] kept_total;

   modport source (output valid, out_word, word_valid, is_last, status, kept_total,
                   input ready);
   modport sink   (input valid, out_word, word_valid, is_last, status, kept_total,
                   output ready);
endinterface

>>> rtl/spirv_debug_instruction_filter_core.sv
// Strips debug instructions (SourceContinued, Source, SourceExtension, Line, NoLine)
// from a SPIR-V word stream, one word per transaction. The five header words pass
// untouched; each following instruction is kept or dropped whole. A transaction
// comes out only for a kept word or for the word flagged end_of_module; that closing
// transaction carries is_last, the status and the kept total. A zero word count or an
// instruction cut short by the end of the module sets status to malformed, after which
// no further words are sent and the kept total reads 0. Throughput is one word per cycle
// while the consumer holds ready high; an accepted word goes into the input register, then
// the filter state update writes the result register. All state returns to reset after
// the closing word, ready for the next module.
module spirv_debug_instruction_filter_core import sdif_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   sdif_req_if.sink   req_chan,
   sdif_rsp_if.source rsp_chan
);

   // input stage
   logic              in_valid_ff, in_valid_in;
   logic [WORD_W-1:0] in_word_ff;
   logic              in_last_ff;

   // filter state
   logic [HDR_W-1:0]  hdr_left_ff, hdr_left_in;
   logic [HALF_W-1:0] words_left_ff, words_left_in;
   logic              dropping_ff, dropping_in;
   logic              error_ff, error_in;
   logic [KEPT_W-1:0] kept_ff, kept_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic              rsp_wvalid_ff, rsp_wvalid_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [KEPT_W-1:0] rsp_total_ff, rsp_total_in;

   logic              out_free, advance, take_in, keep, emit;
   logic [HALF_W-1:0] cnt;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign take_in        = req_chan.valid && req_chan.ready;
   assign cnt            = in_word_ff[WORD_W-1:HALF_W];

   always_comb begin
      in_valid_in   = take_in ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      hdr_left_in   = hdr_left_ff;
      words_left_in = words_left_ff;
      dropping_in   = dropping_ff;
      error_in      = error_ff;
      kept_in       = kept_ff;
      keep          = 1'b0;
      emit          = 1'b0;
      rsp_valid_in  = (rsp_valid_ff && !rsp_chan.ready);
      rsp_word_in   = rsp_word_ff;
      rsp_wvalid_in = rsp_wvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      rsp_total_in  = rsp_total_ff;

      if (advance) begin
         if (!error_ff) begin
            if (hdr_left_ff != '0) begin
               hdr_left_in = hdr_left_ff - HDR_W'(1);
               keep        = 1'b1;
            end else if (words_left_ff == '0) begin
               if (cnt == '0) begin
                  error_in = 1'b1;
               end else begin
                  dropping_in   = is_debug_op(in_word_ff[HALF_W-1:0]);
                  words_left_in = cnt - HALF_W'(1);
                  keep          = !dropping_in;
               end
            end else begin
               words_left_in = words_left_ff - HALF_W'(1);
               keep          = !dropping_ff;
            end
            // module ends mid-instruction
            if (!error_in && in_last_ff && hdr_left_in == '0 && words_left_in != '0) begin
               error_in = 1'b1;
            end
            if (error_in) begin
               keep = 1'b0;
            end
         end

         if (keep && kept_ff < KEPT_CAP) begin
            kept_in = kept_ff + KEPT_W'(1);
         end

         emit = keep || in_last_ff;
         if (emit) begin
            rsp_valid_in  = 1'b1;
            rsp_word_in   = keep ? in_word_ff : '0;
            rsp_wvalid_in = keep;
            rsp_last_in   = in_last_ff;
            rsp_status_in = error_in;
            rsp_total_in  = (in_last_ff && !error_in) ? kept_in : '0;
         end

         if (in_last_ff) begin
            hdr_left_in   = HDR_RESET;
            words_left_in = '0;
            dropping_in   = 1'b0;
            error_in      = 1'b0;
            kept_in       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         hdr_left_ff   <= HDR_RESET;
         words_left_ff <= '0;
         dropping_ff   <= 1'b0;
         error_ff      <= 1'b0;
         kept_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         hdr_left_ff   <= hdr_left_in;
         words_left_ff <= words_left_in;
         dropping_ff   <= dropping_in;
         error_ff      <= error_in;
         kept_ff       <= kept_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         in_word_ff <= req_chan.word;
         in_last_ff <= req_chan.end_of_module;
      end
      rsp_word_ff   <= rsp_word_in;
      rsp_wvalid_ff <= rsp_wvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_word   = rsp_word_ff;
   assign rsp_chan.word_valid = rsp_wvalid_ff;
   assign rsp_chan.is_last    = rsp_last_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.kept_total = rsp_total_ff;

endmodule
